// File: hw/rtl/fxalu_pkg.sv
// shared types and constants for the q24.8 fixed-point alu
// no dependencies; used by the top level and its checker
package fxalu_pkg;

    localparam int WORD_W        = 32;
    localparam int MODE_W        = 4;
    localparam int FRAC_BITS_DEF = 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUB   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MUL   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DIV   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MIN   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MAX   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_INC   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DEC   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_WHOLE = 4'd8;

    // where an item's result comes from inside the pipeline
    localparam logic [1:0] KIND_SIMPLE = 2'd0;
    localparam logic [1:0] KIND_MUL    = 2'd1;
    localparam logic [1:0] KIND_DIV    = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] first_operand;
        logic signed [WORD_W-1:0] second_operand;
    } op_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                     divide_by_zero;
        logic                     is_less;
        logic                     is_equal;
        logic                     is_greater;
    } res_t;

endpackage

// File: hw/rtl/fixed_point_q24_8_alu.sv
// signed q24.8 fixed-point alu: add, sub, mul, div, min, max, inc, dec, whole number
// depends on fxalu_pkg
// an accepted item passes the input, compare, divider-lane and output registers before done
// throughput: one item per cycle; busy stays low, the receiver cannot stall
// the divider is a pipeline of 32 + FRAC_BITS restoring steps, one quotient bit per stage
// reset clears the valid bits only; no item in flight survives reset
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fxalu_pkg::op_t   operation,
    output logic             done,
    output fxalu_pkg::res_t  outcome
);

    localparam int W  = fxalu_pkg::WORD_W;
    localparam int W2 = 2 * W;
    localparam int N  = W + FRAC_BITS;
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef struct packed {
        logic [1:0]   kind;
        logic         neg;
        logic         dz;
        logic [W-1:0] side;
        logic         less;
        logic         equal;
        logic         greater;
        logic [W-1:0] divisor;
        logic [W-1:0] rem;
        logic [N-1:0] dq;
    } lane_t;

    // stage 1: input register
    logic           s1_valid_reg;
    fxalu_pkg::op_t s1_op_reg;

    // stage 2: magnitudes and compare
    logic                          s2_valid_reg;
    logic [fxalu_pkg::MODE_W-1:0]  s2_mode_reg;
    logic [W-1:0]                  s2_a_reg;
    logic [W-1:0]                  s2_b_reg;
    logic [W-1:0]                  s2_am_reg;
    logic [W-1:0]                  s2_bm_reg;
    logic                          s2_an_reg;
    logic                          s2_neg_reg;
    logic                          s2_bz_reg;
    logic                          s2_less_reg;
    logic                          s2_equal_reg;
    logic                          s2_greater_reg;

    logic [W-1:0] s2_a_next;
    logic [W-1:0] s2_b_next;
    logic [W-1:0] s2_am_next;
    logic [W-1:0] s2_bm_next;

    // stage 3 onward: divider lanes
    logic         valid_reg [0:N];
    lane_t        lane_reg  [0:N];
    lane_t        lane0_next;
    logic [W2-1:0] prod_reg;
    logic [W2-1:0] prod_next;
    logic [W-1:0]  whole;

    // output register
    logic            done_reg;
    fxalu_pkg::res_t outcome_reg;
    fxalu_pkg::res_t outcome_next;
    logic [W-1:0]    quot;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            valid_reg[0] <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            valid_reg[0] <= s2_valid_reg;
            done_reg     <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_op_reg <= operation;
        end
    end

    always_comb
    begin
        s2_a_next  = s1_op_reg.first_operand;
        s2_b_next  = s1_op_reg.second_operand;
        s2_am_next = s2_a_next[W-1] ? (~s2_a_next + 1'b1) : s2_a_next;
        s2_bm_next = s2_b_next[W-1] ? (~s2_b_next + 1'b1) : s2_b_next;
    end

    always_ff @(posedge clk)
    begin
        s2_mode_reg    <= s1_op_reg.mode;
        s2_a_reg       <= s2_a_next;
        s2_b_reg       <= s2_b_next;
        s2_am_reg      <= s2_am_next;
        s2_bm_reg      <= s2_bm_next;
        s2_an_reg      <= s2_a_next[W-1];
        s2_neg_reg     <= s2_a_next[W-1] ^ s2_b_next[W-1];
        s2_bz_reg      <= (s2_b_next == '0);
        s2_less_reg    <= $signed(s2_a_next) < $signed(s2_b_next);
        s2_equal_reg   <= (s2_a_next == s2_b_next);
        s2_greater_reg <= $signed(s2_a_next) > $signed(s2_b_next);
    end

    // stage 3: simple results, product, divider setup
    always_comb
    begin
        whole     = s2_am_reg >> FRAC_BITS;
        prod_next = W2'(s2_am_reg) * W2'(s2_bm_reg);

        lane0_next         = '0;
        lane0_next.kind    = fxalu_pkg::KIND_SIMPLE;
        lane0_next.neg     = s2_neg_reg;
        lane0_next.less    = s2_less_reg;
        lane0_next.equal   = s2_equal_reg;
        lane0_next.greater = s2_greater_reg;
        lane0_next.divisor = s2_bm_reg;
        lane0_next.rem     = '0;
        lane0_next.dq      = {s2_am_reg, {FRAC_BITS{1'b0}}};

        case (s2_mode_reg)
            fxalu_pkg::MODE_ADD:   lane0_next.side = s2_a_reg + s2_b_reg;
            fxalu_pkg::MODE_SUB:   lane0_next.side = s2_a_reg - s2_b_reg;
            fxalu_pkg::MODE_MUL:
            begin
                lane0_next.kind = fxalu_pkg::KIND_MUL;
                lane0_next.side = '0;
            end
            fxalu_pkg::MODE_DIV:
            begin
                if (s2_bz_reg)
                begin
                    lane0_next.dz   = 1'b1;
                    lane0_next.side = s2_a_reg;
                end
                else
                begin
                    lane0_next.kind = fxalu_pkg::KIND_DIV;
                    lane0_next.side = '0;
                end
            end
            fxalu_pkg::MODE_MIN:   lane0_next.side = s2_less_reg ? s2_a_reg : s2_b_reg;
            fxalu_pkg::MODE_MAX:   lane0_next.side = s2_greater_reg ? s2_a_reg : s2_b_reg;
            fxalu_pkg::MODE_INC:   lane0_next.side = s2_a_reg + ONE;
            fxalu_pkg::MODE_DEC:   lane0_next.side = s2_a_reg - ONE;
            fxalu_pkg::MODE_WHOLE: lane0_next.side = s2_an_reg ? (~whole + 1'b1) : whole;
            default:               lane0_next.side = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        lane_reg[0] <= lane0_next;
        prod_reg    <= prod_next;
    end

    // restoring divide steps; the product is folded in on the first step
    for (genvar k = 1; k <= N; k++)
    begin : g_step
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic         ge;
        logic [W-1:0] pm;
        lane_t        lane_next;

        always_comb
        begin
            trial = {lane_reg[k-1].rem, lane_reg[k-1].dq[N-1]};
            diff  = trial - {1'b0, lane_reg[k-1].divisor};
            ge    = !diff[W];
            pm    = prod_reg[FRAC_BITS +: W];

            lane_next     = lane_reg[k-1];
            lane_next.rem = ge ? diff[W-1:0] : trial[W-1:0];
            lane_next.dq  = {lane_reg[k-1].dq[N-2:0], ge};
            if (k == 1 && lane_reg[k-1].kind == fxalu_pkg::KIND_MUL)
            begin
                lane_next.side = lane_reg[k-1].neg ? (~pm + 1'b1) : pm;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            lane_reg[k] <= lane_next;
        end
    end

    // output stage
    always_comb
    begin
        quot = lane_reg[N].dq[W-1:0];
        outcome_next.divide_by_zero = lane_reg[N].dz;
        outcome_next.is_less        = lane_reg[N].less;
        outcome_next.is_equal       = lane_reg[N].equal;
        outcome_next.is_greater     = lane_reg[N].greater;
        if (lane_reg[N].kind == fxalu_pkg::KIND_DIV)
        begin
            outcome_next.result = lane_reg[N].neg ? (~quot + 1'b1) : quot;
        end
        else
        begin
            outcome_next.result = lane_reg[N].side;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
    end

    assign done    = done_reg;
    assign outcome = outcome_reg;

endmodule

// File: hw/rtl/fxalu_checker.sv
// port-level checks for the q24.8 fixed-point alu, bound to the top level
// depends on fxalu_pkg and fixed_point_q24_8_alu
module fxalu_checker #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input fxalu_pkg::op_t  operation,
    input logic            done,
    input fxalu_pkg::res_t outcome
);

    localparam int LAT = fxalu_pkg::WORD_W + FRAC_BITS + 4;

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item did not complete on time");

    // no result without an accepted item
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted item");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot({outcome.is_less, outcome.is_equal, outcome.is_greater}))
        else $error("compare flags not one-hot");

    a_dz_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome.divide_by_zero) |->
            $past(operation.mode == fxalu_pkg::MODE_DIV && operation.second_operand == '0,
                  LAT))
        else $error("divide by zero flag without a zero divisor");

    a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome.divide_by_zero) |->
            outcome.result == $past(operation.first_operand, LAT))
        else $error("divide by zero result is not the dividend");

endmodule

bind fixed_point_q24_8_alu fxalu_checker #(.FRAC_BITS(FRAC_BITS)) u_fxalu_checker (.*);

// File: tb/fixed_point_q24_8_alu_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the q24.8 fixed-point alu: directed corner items, then random
// items in bursts, each result checked in order against a local prediction
// depends on fxalu_pkg and fixed_point_q24_8_alu
module fixed_point_q24_8_alu_test;

    localparam int          FRAC       = fxalu_pkg::FRAC_BITS_DEF;
    localparam logic [31:0] ONE_UNIT   = 32'd1 << FRAC;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          DRAIN_WAIT = 60;
    localparam int          RAND_ITEMS = 400;

    typedef struct {
        fxalu_pkg::op_t op;
        bit             drain_first;
    } queued_op_t;

    logic            clk   = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    fxalu_pkg::op_t  operation = '0;
    logic            busy;
    logic            done;
    fxalu_pkg::res_t outcome;

    queued_op_t      queued_ops[$];
    fxalu_pkg::res_t pending_outcomes[$];
    int              error_count = 0;
    int              gap_left    = 0;
    int              burst_left  = 1;
    int              idle_cycles = 0;

    fixed_point_q24_8_alu i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .done      (done),
        .outcome   (outcome)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic fxalu_pkg::res_t alu_outcome(fxalu_pkg::op_t op);
        logic [31:0]     a;
        logic [31:0]     b;
        logic [31:0]     a_mag;
        logic [31:0]     b_mag;
        logic [63:0]     wide;
        logic            neg;
        fxalu_pkg::res_t r;
        a     = op.first_operand;
        b     = op.second_operand;
        a_mag = a[31] ? -a : a;
        b_mag = b[31] ? -b : b;
        neg   = a[31] ^ b[31];
        r     = '0;
        r.is_less    = $signed(a) < $signed(b);
        r.is_equal   = a == b;
        r.is_greater = $signed(a) > $signed(b);
        case (op.mode)
            fxalu_pkg::MODE_ADD:   r.result = a + b;
            fxalu_pkg::MODE_SUB:   r.result = a - b;
            fxalu_pkg::MODE_MUL:
            begin
                wide     = ({32'b0, a_mag} * {32'b0, b_mag}) >> FRAC;
                r.result = neg ? -wide[31:0] : wide[31:0];
            end
            fxalu_pkg::MODE_DIV:
            begin
                if (b == 32'd0)
                begin
                    r.result         = a;
                    r.divide_by_zero = 1'b1;
                end
                else
                begin
                    wide     = ({32'b0, a_mag} << FRAC) / {32'b0, b_mag};
                    r.result = neg ? -wide[31:0] : wide[31:0];
                end
            end
            fxalu_pkg::MODE_MIN:   r.result = r.is_less ? a : b;
            fxalu_pkg::MODE_MAX:   r.result = r.is_greater ? a : b;
            fxalu_pkg::MODE_INC:   r.result = a + ONE_UNIT;
            fxalu_pkg::MODE_DEC:   r.result = a - ONE_UNIT;
            fxalu_pkg::MODE_WHOLE: r.result = a[31] ? -(a_mag >> FRAC) : (a_mag >> FRAC);
            default:               r.result = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'($urandom_range(0, 4095)) - 32'd2048;
            4:       return {16'($urandom_range(0, 65535)) - 16'd32768, 8'($urandom), 8'h00} >>> 8;
            5:       return {$urandom_range(0, 1) ? 24'hffffff : 24'h000000, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [fxalu_pkg::MODE_W-1:0] mode, logic [31:0] a,
                            logic [31:0] b, bit drain_first);
        queued_op_t q;
        q.op.mode           = mode;
        q.op.first_operand  = a;
        q.op.second_operand = b;
        q.drain_first       = drain_first;
        queued_ops.push_back(q);
    endtask

    // driver: bursts of items with random gaps, optional drain before an item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            operation <= '0;
        end
        else
        begin
            if (start && !busy)
                pending_outcomes.push_back(alu_outcome(operation));
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (queued_ops.size() != 0 &&
                         !(queued_ops[0].drain_first && pending_outcomes.size() != 0))
                begin
                    start     <= 1'b1;
                    operation <= queued_ops[0].op;
                    queued_ops.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                                 : $urandom_range(1, 30);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 3);
                            default: gap_left = $urandom_range(1, 60);
                        endcase
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        fxalu_pkg::res_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: result=%h dz=%b lt=%b eq=%b gt=%b",
                             outcome.result, outcome.divide_by_zero, outcome.is_less,
                             outcome.is_equal, outcome.is_greater);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (outcome.result !== want.result ||
                    outcome.divide_by_zero !== want.divide_by_zero ||
                    outcome.is_less !== want.is_less ||
                    outcome.is_equal !== want.is_equal ||
                    outcome.is_greater !== want.is_greater)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected %h/%b%b%b%b got %h/%b%b%b%b",
                                 want.result, want.divide_by_zero, want.is_less,
                                 want.is_equal, want.is_greater,
                                 outcome.result, outcome.divide_by_zero, outcome.is_less,
                                 outcome.is_equal, outcome.is_greater);
                end
            end
        end
    end

    // watchdog on cycles with neither an accepted item nor a result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles++;
        end
    end

    initial
    begin
        logic [fxalu_pkg::MODE_W-1:0] mode;
        logic [31:0]                  a;
        logic [31:0]                  b;

        queue_op(fxalu_pkg::MODE_ADD,   32'h7fff_ffff, 32'h0000_0001, 1'b0);
        queue_op(fxalu_pkg::MODE_ADD,   32'h8000_0000, 32'hffff_ffff, 1'b0);
        queue_op(fxalu_pkg::MODE_SUB,   32'h8000_0000, 32'h0000_0001, 1'b0);
        queue_op(fxalu_pkg::MODE_SUB,   32'h0000_0000, 32'h8000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_MUL,   32'h0000_0100, 32'h0000_0100, 1'b0);
        queue_op(fxalu_pkg::MODE_MUL,   32'hffff_ff80, 32'h0000_0180, 1'b0);
        queue_op(fxalu_pkg::MODE_MUL,   32'h8000_0000, 32'h8000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_MUL,   32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        queue_op(fxalu_pkg::MODE_MUL,   32'hffff_ffff, 32'h0000_0001, 1'b0);
        queue_op(fxalu_pkg::MODE_DIV,   32'h1234_5678, 32'h0000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_DIV,   32'h8000_0000, 32'h0000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_DIV,   32'h8000_0000, 32'hffff_ff00, 1'b0);
        queue_op(fxalu_pkg::MODE_DIV,   32'h0000_0300, 32'h0000_0200, 1'b0);
        queue_op(fxalu_pkg::MODE_DIV,   32'hffff_ffff, 32'h7fff_ffff, 1'b0);
        queue_op(fxalu_pkg::MODE_DIV,   32'h7fff_ffff, 32'h0000_0001, 1'b0);
        queue_op(fxalu_pkg::MODE_MIN,   32'h8000_0000, 32'h7fff_ffff, 1'b0);
        queue_op(fxalu_pkg::MODE_MIN,   32'hffff_fe00, 32'hffff_fe00, 1'b0);
        queue_op(fxalu_pkg::MODE_MAX,   32'h7fff_ffff, 32'h8000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_INC,   32'h7fff_ffff, 32'h0000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_DEC,   32'h8000_0000, 32'h0000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_WHOLE, 32'hffff_ffff, 32'h0000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_WHOLE, 32'h8000_0000, 32'h0000_0000, 1'b0);
        queue_op(fxalu_pkg::MODE_WHOLE, 32'hffff_ff00, 32'h7fff_ffff, 1'b0);
        queue_op(4'd9,                  32'h0000_0005, 32'h0000_0005, 1'b0);
        queue_op(4'd15,                 32'hffff_ffff, 32'h0000_0000, 1'b0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            mode = ($urandom_range(0, 19) < 18) ? 4'($urandom_range(0, 8))
                                                : 4'($urandom_range(9, 15));
            a = random_operand();
            b = ($urandom_range(0, 3) == 0) ? a : random_operand();
            if (mode == fxalu_pkg::MODE_DIV && $urandom_range(0, 7) == 0)
                b = 32'h0000_0000;
            queue_op(mode, a, b, i == 0 || i == RAND_ITEMS / 2);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_ops.size() != 0 || start)
            @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        error_count += pending_outcomes.size();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/fxalu_pkg.sv
hw/rtl/fixed_point_q24_8_alu.sv
hw/rtl/fxalu_checker.sv
tb/fixed_point_q24_8_alu_test.sv
